[rtl/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

[rtl/astc_pkg.sv]
package astc_pkg;

   localparam int REF_W   = 228;
   localparam int TOP_W   = 36;
   localparam int TIME_W  = 48;
   localparam int HGT_W   = 24;
   localparam int SPC_W   = 16;
   localparam int HL_W    = 32;
   localparam int MAG_W   = 48;
   localparam int DIVD_W  = 64;
   localparam int FRAC_W  = 16;
   localparam int FACT_W  = 17;
   localparam int PROD_W  = 256;
   localparam int SH_W    = 50;
   localparam int DIV_STEPS = 64;

   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [SPC_W-1:0] SPACING_RST = 16'd600;
   localparam logic [HL_W-1:0]  HALF_LIFE_RST = 32'd86400;
   localparam logic [REF_W-1:0] LIMIT_RST = {36'h0FFFFFFFF, {192{1'b1}}};

   // cubic 2^x approximation coefficients
   localparam logic [47:0] COEF_A = 48'd195766423245049;
   localparam logic [29:0] COEF_B = 30'd971821376;
   localparam logic [12:0] COEF_C = 13'd5127;
   localparam logic [63:0] ROUND_HALF = 64'h0000_8000_0000_0000;
   localparam logic [FACT_W-1:0] FRAC_ONE = 17'd65536;

   typedef enum logic [2:0] {
      CSR_SPACING   = 3'd0,
      CSR_HALF_LIFE = 3'd1,
      CSR_LIMIT_W0  = 3'd2,
      CSR_LIMIT_W1  = 3'd3,
      CSR_LIMIT_W2  = 3'd4,
      CSR_LIMIT_W3  = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      CLAMP_NONE    = 2'd0,
      CLAMP_RAISED  = 2'd1,
      CLAMP_LIMITED = 2'd2
   } clamp_type;

   typedef struct packed {
      logic [SPC_W-1:0] spacing;
      logic [HL_W-1:0]  half_life;
      logic [REF_W-1:0] limit;
   } csr_type;

   typedef struct packed {
      logic [REF_W-1:0] ref_tgt;
      logic [MAG_W-1:0] mag;
      logic             neg;
      logic             bad;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic afull;
   } queue_status_type;

   typedef struct packed {
      logic [HL_W-1:0]   rem;
      logic [DIVD_W-1:0] quo;
      logic [REF_W-1:0]  ref_tgt;
      logic              neg;
      logic              bad;
   } div_stage_type;

endpackage

[rtl/astc_front.sv]
module astc_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [63:0]                    req_ref_w0,
   input  logic [63:0]                    req_ref_w1,
   input  logic [63:0]                    req_ref_w2,
   input  logic [astc_pkg::TOP_W-1:0]     req_ref_w3,
   input  logic signed [astc_pkg::TIME_W-1:0] req_time_diff,
   input  logic [astc_pkg::HGT_W-1:0]     req_height_diff,
   input  astc_pkg::csr_type              csr,
   input  astc_pkg::queue_status_type     qstat,
   output logic                           push,
   output astc_pkg::queue_entry_type      push_entry
);
   import astc_pkg::*;

   logic                f1_valid_ff, f1_valid_in;
   logic [REF_W-1:0]    f1_ref_ff;
   logic [TIME_W-1:0]   f1_time_ff;
   logic [HGT_W-1:0]    f1_hgt_ff;
   logic                req_acc;
   logic [39:0]         sp_hd;
   logic [40:0]         sched;
   logic [SH_W-1:0]     t_ext, span, d, mag_full;
   logic                span_big, ref_bad;

   // one slot in the queue stays reserved for the item held here
   assign req_stall   = qstat.full || (f1_valid_ff && qstat.afull);
   assign req_acc     = req_valid && !req_stall;
   assign f1_valid_in = req_acc;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= f1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         f1_ref_ff  <= {req_ref_w3, req_ref_w2, req_ref_w1, req_ref_w0};
         f1_time_ff <= req_time_diff;
         f1_hgt_ff  <= req_height_diff;
      end
   end

   // schedule and span
   always_comb begin
      sp_hd    = 40'(csr.spacing) * 40'(f1_hgt_ff);
      sched    = {1'b0, sp_hd} + 41'(csr.spacing);
      t_ext    = {{2{f1_time_ff[TIME_W-1]}}, f1_time_ff};
      span     = t_ext - {10'b0, sp_hd};
      d        = t_ext - {9'b0, sched};
      mag_full = d[SH_W-1] ? (~d + 50'd1) : d;
      span_big = (span[49:47] != 3'b000 && span[49:47] != 3'b111) ||
                 (span == {3'b111, 47'b0});
      ref_bad  = (f1_ref_ff == '0) || (f1_ref_ff > csr.limit);
   end

   // classified item into the queue
   assign push               = f1_valid_ff;
   assign push_entry.ref_tgt = f1_ref_ff;
   assign push_entry.mag     = mag_full[MAG_W-1:0];
   assign push_entry.neg     = d[SH_W-1];
   assign push_entry.bad     = span_big || ref_bad;

endmodule

[rtl/astc_fifo.sv]
`include "assert_macros.svh"

module astc_fifo #(
   parameter int DEPTH = astc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  astc_pkg::queue_entry_type   wdata,
   input  logic                        pop,
   output astc_pkg::queue_entry_type   rdata,
   output logic                        empty,
   output astc_pkg::queue_status_type  qstat
);
   import astc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   queue_entry_type   mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   assign rdata       = mem_ff[rd_ptr_ff];
   assign empty       = (count_ff == '0);
   assign qstat.full  = (count_ff == CNT_W'(DEPTH));
   assign qstat.afull = (count_ff >= CNT_W'(DEPTH - 1));

   `ASSERT_IMPLY(a_push_room, clock, reset, push, count_ff != CNT_W'(DEPTH), "queue write while full")
   `ASSERT_IMPLY(a_pop_data, clock, reset, pop, count_ff != '0, "queue read while empty")
   `ASSERT_NEXT(a_push_fill, clock, reset, push && !pop, count_ff != '0, "queue lost an item")

endmodule

[rtl/astc_div.sv]
module astc_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic [astc_pkg::HL_W-1:0]  half_life,
   input  logic                       in_valid,
   input  astc_pkg::queue_entry_type  in_entry,
   output logic                       out_valid,
   output astc_pkg::div_stage_type    out_stage
);
   import astc_pkg::*;

   div_stage_type         stg_ff [DIV_STEPS+1];
   logic [DIV_STEPS:0]    vld_ff;
   logic [HL_W-1:0]       hl;
   div_stage_type         init;

   // one restoring quotient bit per stage
   function automatic div_stage_type div_step(input div_stage_type s,
                                              input logic [HL_W-1:0] dv);
      logic [HL_W:0] part;
      logic [HL_W:0] diff;
      logic          take;
      div_stage_type o;
      o    = s;
      part = {s.rem, s.quo[DIVD_W-1]};
      diff = part - {1'b0, dv};
      take = (part >= {1'b0, dv});
      o.rem = take ? diff[HL_W-1:0] : part[HL_W-1:0];
      o.quo = {s.quo[DIVD_W-2:0], take};
      return o;
   endfunction

   // zero half life acts as one
   assign hl = (half_life == '0) ? HL_W'(1) : half_life;

   always_comb begin
      init.rem     = '0;
      init.quo     = {in_entry.mag, 16'b0};
      init.ref_tgt = in_entry.ref_tgt;
      init.neg     = in_entry.neg;
      init.bad     = in_entry.bad;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DIV_STEPS-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stg_ff[0] <= init;
         for (int k = 1; k <= DIV_STEPS; k++) begin
            stg_ff[k] <= div_step(stg_ff[k-1], hl);
         end
      end
   end

   assign out_valid = vld_ff[DIV_STEPS];
   assign out_stage = stg_ff[DIV_STEPS];

endmodule

[rtl/astc_back.sv]
module astc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  astc_pkg::div_stage_type       in_stage,
   input  logic [astc_pkg::REF_W-1:0]    limit,
   output logic                          adv,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [astc_pkg::REF_W-1:0]    rsp_next,
   output logic [1:0]                    rsp_clamp_kind,
   output logic                          rsp_bad_input
);
   import astc_pkg::*;

   logic [7:0]          vld_ff;
   logic                rsp_valid_ff;
   // exponent stage
   logic [SH_W-1:0]     e_sh_ff, e_sh_in, shifts;
   logic [FRAC_W-1:0]   e_f_ff, e_f_in, fr;
   logic [SH_W-1:0]     qi;
   logic [REF_W-1:0]    ref_ff [5];
   logic                bad_ff [8];
   logic [SH_W-1:0]     sh_ff [6];
   // factor stages
   logic [63:0]         af_ff [3];
   logic [31:0]         f2_ff;
   logic [FRAC_W-1:0]   f1_f_ff;
   logic [61:0]         bf2_ff [2];
   logic [47:0]         f3_ff;
   logic [60:0]         cf3_ff;
   logic [63:0]         sum;
   logic [FACT_W-1:0]   fact_ff;
   // product stages
   logic [80:0]         p0_ff, p1_ff, p2_ff;
   logic [52:0]         p3_ff;
   logic [PROD_W-1:0]   prod_ff;
   // shift stage
   logic                sh_left, sh_big, over_in, over_ff;
   logic [SH_W-1:0]     sh_mag;
   logic [7:0]          n8;
   logic [PROD_W-1:0]   shr_in, shr_ff, lim256, val;
   // output
   logic [REF_W-1:0]    next_ff, next_in;
   clamp_type           kind_ff, kind_in;
   logic                rbad_ff;

   assign adv = !rsp_valid_ff || !rsp_stall;
   assign lim256 = {28'b0, limit};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[6:0], in_valid};
         rsp_valid_ff <= vld_ff[7];
      end
   end

   // split exponent into integer shift and fraction
   always_comb begin
      fr = in_stage.quo[FRAC_W-1:0];
      qi = {2'b0, in_stage.quo[DIVD_W-1:FRAC_W]};
      if (!in_stage.neg || in_stage.quo == '0) begin
         shifts = qi;
         e_f_in = fr;
      end else begin
         shifts = ~(qi + {49'b0, (fr != '0)}) + 50'd1;
         e_f_in = ~fr + 16'd1;
      end
      e_sh_in = shifts - 50'd16;
   end

   // shift amount, direction and overflow mask
   always_comb begin
      sh_left = !sh_ff[5][SH_W-1] && (sh_ff[5] != '0);
      sh_mag  = sh_ff[5][SH_W-1] ? (~sh_ff[5] + 50'd1) : sh_ff[5];
      sh_big  = |sh_mag[SH_W-1:8];
      n8      = sh_mag[7:0];
      over_in = 1'b0;
      shr_in  = '0;
      if (sh_left) begin
         if (sh_big) begin
            over_in = |prod_ff;
         end else begin
            shr_in  = prod_ff << n8;
            over_in = |(prod_ff & ~({PROD_W{1'b1}} >> n8));
         end
      end else if (!sh_big) begin
         shr_in = prod_ff >> n8;
      end
   end

   // clamp into one..limit
   always_comb begin
      val = over_ff ? lim256 : shr_ff;
      if (val == '0) begin
         next_in = REF_W'(1);
         kind_in = CLAMP_RAISED;
      end else if (val > lim256) begin
         next_in = limit;
         kind_in = CLAMP_LIMITED;
      end else begin
         next_in = val[REF_W-1:0];
         kind_in = over_ff ? CLAMP_LIMITED : CLAMP_NONE;
      end
   end

   assign sum = af_ff[2] + {2'b0, bf2_ff[1]} + {3'b0, cf3_ff} + ROUND_HALF;

   // datapath registers, all advance together
   always_ff @(posedge clock) begin
      if (adv) begin
         // exponent
         e_sh_ff   <= e_sh_in;
         e_f_ff    <= e_f_in;
         ref_ff[0] <= in_stage.ref_tgt;
         bad_ff[0] <= in_stage.bad;
         // factor terms
         af_ff[0]  <= 64'(COEF_A) * 64'(e_f_ff);
         f2_ff     <= 32'(e_f_ff) * 32'(e_f_ff);
         f1_f_ff   <= e_f_ff;
         sh_ff[0]  <= e_sh_ff;
         bf2_ff[0] <= 62'(COEF_B) * 62'(f2_ff);
         f3_ff     <= 48'(f2_ff) * 48'(f1_f_ff);
         af_ff[1]  <= af_ff[0];
         cf3_ff    <= 61'(COEF_C) * 61'(f3_ff);
         bf2_ff[1] <= bf2_ff[0];
         af_ff[2]  <= af_ff[1];
         fact_ff   <= FRAC_ONE + {1'b0, sum[63:48]};
         // target times factor, one lane per word
         p0_ff     <= 81'(ref_ff[4][63:0]) * 81'(fact_ff);
         p1_ff     <= 81'(ref_ff[4][127:64]) * 81'(fact_ff);
         p2_ff     <= 81'(ref_ff[4][191:128]) * 81'(fact_ff);
         p3_ff     <= 53'(ref_ff[4][227:192]) * 53'(fact_ff);
         prod_ff   <= {175'b0, p0_ff} + {111'b0, p1_ff, 64'b0} +
                      {47'b0, p2_ff, 128'b0} + {11'b0, p3_ff, 192'b0};
         shr_ff    <= shr_in;
         over_ff   <= over_in;
         next_ff   <= next_in;
         kind_ff   <= kind_in;
         rbad_ff   <= bad_ff[7];
         for (int k = 1; k < 5; k++) begin
            ref_ff[k] <= ref_ff[k-1];
         end
         for (int k = 1; k < 8; k++) begin
            bad_ff[k] <= bad_ff[k-1];
         end
         for (int k = 1; k < 6; k++) begin
            sh_ff[k] <= sh_ff[k-1];
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_next       = next_ff;
   assign rsp_clamp_kind = kind_ff;
   assign rsp_bad_input  = rbad_ff;

endmodule

[rtl/asert_target_calc.sv]
// throughput: one item per cycle while rsp_stall is low, set by the 64-stage
//   pipelined divider and the pipelined factor and product multipliers; a queue
//   of QUEUE_DEPTH entries, 4 by default, splits front and back
// reset: synchronous, clears valids, queue pointers and restores register defaults
module asert_target_calc #(
   parameter int QUEUE_DEPTH = astc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [63:0]                    req_ref_w0,
   input  logic [63:0]                    req_ref_w1,
   input  logic [63:0]                    req_ref_w2,
   input  logic [astc_pkg::TOP_W-1:0]     req_ref_w3,
   input  logic signed [astc_pkg::TIME_W-1:0] req_time_diff,
   input  logic [astc_pkg::HGT_W-1:0]     req_height_diff,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [63:0]                    rsp_next_w0,
   output logic [63:0]                    rsp_next_w1,
   output logic [63:0]                    rsp_next_w2,
   output logic [astc_pkg::TOP_W-1:0]     rsp_next_w3,
   output logic [1:0]                     rsp_clamp_kind,
   output logic                           rsp_bad_input,
   input  logic                           csr_wr_en,
   input  logic [2:0]                     csr_index,
   input  logic [63:0]                    csr_wr_data
);
   import astc_pkg::*;

   csr_type           csr_ff, csr_in;
   queue_status_type  qstat;
   queue_entry_type   push_entry, pop_entry;
   logic              push, pop, empty, adv;
   logic              div_valid;
   div_stage_type     div_out;
   logic [REF_W-1:0]  next_tgt;

   // configuration writes
   always_comb begin
      csr_in = csr_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SPACING:   csr_in.spacing = csr_wr_data[SPC_W-1:0];
            CSR_HALF_LIFE: csr_in.half_life = csr_wr_data[HL_W-1:0];
            CSR_LIMIT_W0:  csr_in.limit[63:0] = csr_wr_data;
            CSR_LIMIT_W1:  csr_in.limit[127:64] = csr_wr_data;
            CSR_LIMIT_W2:  csr_in.limit[191:128] = csr_wr_data;
            CSR_LIMIT_W3:  csr_in.limit[227:192] = csr_wr_data[TOP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.spacing   <= SPACING_RST;
         csr_ff.half_life <= HALF_LIFE_RST;
         csr_ff.limit     <= LIMIT_RST;
      end else begin
         csr_ff <= csr_in;
      end
   end

   astc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_ref_w0      (req_ref_w0),
      .req_ref_w1      (req_ref_w1),
      .req_ref_w2      (req_ref_w2),
      .req_ref_w3      (req_ref_w3),
      .req_time_diff   (req_time_diff),
      .req_height_diff (req_height_diff),
      .csr             (csr_ff),
      .qstat           (qstat),
      .push            (push),
      .push_entry      (push_entry)
   );

   astc_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (push_entry),
      .pop   (pop),
      .rdata (pop_entry),
      .empty (empty),
      .qstat (qstat)
   );

   assign pop = adv && !empty;

   astc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .half_life (csr_ff.half_life),
      .in_valid  (!empty),
      .in_entry  (pop_entry),
      .out_valid (div_valid),
      .out_stage (div_out)
   );

   astc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (div_valid),
      .in_stage       (div_out),
      .limit          (csr_ff.limit),
      .adv            (adv),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_next       (next_tgt),
      .rsp_clamp_kind (rsp_clamp_kind),
      .rsp_bad_input  (rsp_bad_input)
   );

   assign rsp_next_w0 = next_tgt[63:0];
   assign rsp_next_w1 = next_tgt[127:64];
   assign rsp_next_w2 = next_tgt[191:128];
   assign rsp_next_w3 = next_tgt[227:192];

endmodule

[test/tb_asert_target_calc.sv]
module tb_asert_target_calc;
   import astc_pkg::*;

   localparam int LATENCY = 75;

   typedef struct {
      logic [255:0] target;
      clamp_type    kind;
      logic         bad;
   } next_target_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [63:0] req_ref_w0 = '0;
   logic [63:0] req_ref_w1 = '0;
   logic [63:0] req_ref_w2 = '0;
   logic [TOP_W-1:0] req_ref_w3 = '0;
   logic signed [TIME_W-1:0] req_time_diff = '0;
   logic [HGT_W-1:0] req_height_diff = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [63:0] rsp_next_w0, rsp_next_w1, rsp_next_w2;
   logic [TOP_W-1:0] rsp_next_w3;
   logic [1:0] rsp_clamp_kind;
   logic rsp_bad_input;
   logic csr_wr_en = 1'b0;
   logic [2:0] csr_index = '0;
   logic [63:0] csr_wr_data = '0;

   // shadow copy of the registers
   logic [SPC_W-1:0] spacing_sh;
   logic [HL_W-1:0] half_life_sh;
   logic [255:0] limit_sh;

   next_target_type next_target_q[$];
   int mismatches = 0;
   int items_sent = 0;
   int results_seen = 0;
   int raised_seen = 0;
   int limited_seen = 0;
   int bad_seen = 0;
   bit no_gaps = 0;
   bit no_stalls = 0;

   asert_target_calc dut (.*);

   always #10 clock = ~clock;

   // model of one target calculation
   function automatic next_target_type predict_next_target(logic [255:0] ref_tgt,
         longint t, logic [HGT_W-1:0] hd);
      next_target_type r;
      bit [63:0] sp, sched, mag, hlv, q, f, acc, factor, n;
      bit [63:0] ca, cb, cc;
      longint span, d, shifts;
      bit neg, over;
      logic [255:0] prod, res;
      sp = spacing_sh;
      ca = 64'd195766423245049;
      cb = 64'd971821376;
      cc = 64'd5127;
      r.bad = (ref_tgt == 0) || (ref_tgt > limit_sh);
      span = t - longint'(sp * hd);
      if (span < 0) span = -span;
      if (span >= longint'(64'h8000_0000_0000)) r.bad = 1'b1;
      sched = sp * (64'(hd) + 64'd1);
      d = t - longint'(sched);
      neg = d < 0;
      mag = neg ? 64'(-d) : 64'(d);
      hlv = (half_life_sh == 0) ? 64'd1 : 64'(half_life_sh);
      q = (mag << 16) / hlv;
      if (!neg || q == 0) begin
         shifts = longint'(q >> 16);
         f = q & 64'hFFFF;
      end else begin
         shifts = -longint'((q >> 16) + 64'(q[15:0] != 0));
         f = (64'd65536 - 64'(q[15:0])) & 64'hFFFF;
      end
      acc = ca * f + cb * f * f + cc * f * f * f + 64'h8000_0000_0000;
      factor = 64'd65536 + (acc >> 48);
      prod = ref_tgt * 256'(factor);
      r.kind = CLAMP_NONE;
      shifts -= 16;
      if (shifts <= 0) begin
         n = 64'(-shifts);
         res = (n >= 256) ? '0 : (prod >> n);
      end else begin
         n = 64'(shifts);
         if (n >= 256) begin
            over = prod != 0;
            res = '0;
         end else begin
            res = prod << n;
            over = (res >> n) != prod;
         end
         if (over) begin
            res = limit_sh;
            r.kind = CLAMP_LIMITED;
         end
      end
      if (res == 0) begin
         res = 256'd1;
         r.kind = CLAMP_RAISED;
      end else if (res > limit_sh) begin
         res = limit_sh;
         r.kind = CLAMP_LIMITED;
      end
      r.target = {28'd0, res[227:0]};
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // result side stall pattern
   int stall_left = 0;
   always @(negedge clock) begin
      if (no_stalls) begin
         rsp_stall = 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall = 1'b1;
      end else begin
         stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
         rsp_stall = stall_left > 0;
      end
   end

   // compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      next_target_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (next_target_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item %h", rsp_next_w0);
         end else begin
            e = next_target_q.pop_front();
            if (e.kind == CLAMP_RAISED) raised_seen++;
            if (e.kind == CLAMP_LIMITED) limited_seen++;
            if (e.bad) bad_seen++;
            if (rsp_next_w0 !== e.target[63:0] || rsp_next_w1 !== e.target[127:64] ||
                rsp_next_w2 !== e.target[191:128] || rsp_next_w3 !== e.target[227:192] ||
                rsp_clamp_kind !== e.kind || rsp_bad_input !== e.bad) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: expected %h kind %0d bad %0d",
                     e.target[227:0], e.kind, e.bad);
                  $display("          actual   %h%h%h%h kind %0d bad %0d", rsp_next_w3,
                     rsp_next_w2, rsp_next_w1, rsp_next_w0, rsp_clamp_kind, rsp_bad_input);
               end
            end
         end
      end
   end

   // send one item, called at a falling edge
   task automatic send_item(logic [227:0] ref_tgt, logic signed [TIME_W-1:0] t,
         logic [HGT_W-1:0] hd);
      int gap;
      req_ref_w0 = ref_tgt[63:0];
      req_ref_w1 = ref_tgt[127:64];
      req_ref_w2 = ref_tgt[191:128];
      req_ref_w3 = ref_tgt[227:192];
      req_time_diff = t;
      req_height_diff = hd;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      next_target_q.push_back(predict_next_target({28'd0, ref_tgt}, longint'(t), hd));
      items_sent++;
      @(negedge clock);
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid = 1'b0;
      while (next_target_q.size() != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [63:0] data);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wr_data = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         CSR_SPACING:   spacing_sh = data[15:0];
         CSR_HALF_LIFE: half_life_sh = data[31:0];
         CSR_LIMIT_W0:  limit_sh[63:0] = data;
         CSR_LIMIT_W1:  limit_sh[127:64] = data;
         CSR_LIMIT_W2:  limit_sh[191:128] = data;
         CSR_LIMIT_W3:  limit_sh[255:192] = {28'd0, data[35:0]};
         default: ;
      endcase
   endtask

   task automatic set_limit(logic [227:0] lim);
      csr_write(CSR_LIMIT_W0, lim[63:0]);
      csr_write(CSR_LIMIT_W1, lim[127:64]);
      csr_write(CSR_LIMIT_W2, lim[191:128]);
      csr_write(CSR_LIMIT_W3, {28'd0, lim[227:192]});
   endtask

   function automatic logic [227:0] rand_wide();
      logic [255:0] v;
      for (int i = 0; i < 8; i++) v[i*32 +: 32] = $urandom;
      return v[227:0];
   endfunction

   // reference targets of all magnitudes, with zero and the limit edges
   function automatic logic [227:0] rand_target();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return '0;
      if (r < 6) return limit_sh[227:0];
      if (r < 9) return limit_sh[227:0] + 228'd1;
      if (r < 20) return rand_wide();
      return rand_wide() >> $urandom_range(0, 227);
   endfunction

   // mostly near the schedule, so exponents stay in a useful span
   function automatic logic signed [TIME_W-1:0] rand_time(logic [HGT_W-1:0] hd);
      longint sched, off, span;
      logic [63:0] raw;
      if ($urandom_range(0, 9) < 3) return TIME_W'({$urandom, $urandom});
      sched = longint'(64'(spacing_sh) * (64'(hd) + 1));
      span = longint'((half_life_sh == 0 ? 64'd1 : 64'(half_life_sh)) *
         64'($urandom_range(1, 300))) + 1;
      raw = {$urandom, $urandom};
      off = longint'(raw % 64'(span));
      if ($urandom_range(0, 1)) off = -off;
      return TIME_W'(sched + off);
   endfunction

   function automatic logic [HGT_W-1:0] rand_height();
      if ($urandom_range(0, 1)) return HGT_W'($urandom_range(0, 1000));
      return HGT_W'($urandom);
   endfunction

   task automatic random_items(int count);
      logic [HGT_W-1:0] hd;
      for (int i = 0; i < count; i++) begin
         hd = rand_height();
         send_item(rand_target(), rand_time(hd), hd);
      end
   endtask

   // edges of every field under the reset settings
   task automatic test_directed_defaults();
      logic [227:0] lim;
      lim = limit_sh[227:0];
      send_item(228'd1, 48'sd600, 24'd0);
      send_item(228'd0, 48'sd600, 24'd0);
      send_item(lim, 48'sd600, 24'd0);
      send_item(lim + 228'd1, 48'sd600, 24'd0);
      send_item({228{1'b1}}, 48'sd0, 24'd0);
      send_item(lim, 48'sh7FFF_FFFF_FFFF, 24'd0);
      send_item(228'd1, 48'sh8000_0000_0000, 24'hFFFFFF);
      send_item(228'hFFFF, 48'sh8000_0000_0000, 24'd0);
      send_item(228'd12345, 48'sd0, 24'hFFFFFF);
      send_item(228'd65536, 48'sd643200, 24'd1);
      send_item(228'd65536, -48'sd43200, 24'd0);
      send_item(228'd1 << 200, 48'sd86999, 24'd0);
      send_item(228'd1 << 100, 48'sd599, 24'd0);
      send_item(228'd1 << 100, 48'sd601, 24'd0);
   endtask

   // register extremes: zero and maximum half life and spacing, zero and small limits
   task automatic test_register_extremes();
      wait_idle();
      csr_write(CSR_HALF_LIFE, 64'd0);
      csr_write(CSR_SPACING, 64'd0);
      send_item(228'd1000, 48'sd1, 24'd5);
      send_item(228'd1000, -48'sd1, 24'd5);
      send_item(228'd1000, 48'sd0, 24'd0);
      wait_idle();
      csr_write(CSR_SPACING, 64'd65535);
      csr_write(CSR_HALF_LIFE, 64'hFFFF_FFFF);
      send_item(228'd777, 48'sh7FFF_FFFF_FFFF, 24'hFFFFFF);
      send_item(228'd777, 48'sh8000_0000_0000, 24'hFFFFFF);
      send_item(228'd1 << 150, 48'sd0, 24'd0);
      wait_idle();
      set_limit('0);
      send_item(228'd1, 48'sd0, 24'd0);
      send_item(228'd5, 48'sh7FFF_FFFF_FFFF, 24'd0);
      wait_idle();
      set_limit(228'hFFFF_FFFF);
      send_item(228'hFFFF, 48'sh7FFF_FFFF_FFFF, 24'd0);
      send_item(228'h1_0000_0000, 48'sd0, 24'd0);
   endtask

   // random items over a given setting
   task automatic test_random_phase(logic [15:0] sp, logic [31:0] hl, logic [227:0] lim,
         int count);
      wait_idle();
      csr_write(CSR_SPACING, 64'(sp));
      csr_write(CSR_HALF_LIFE, 64'(hl));
      set_limit(lim);
      random_items(count);
   endtask

   // back to back, first without result stalls and the sender then held until all results are in, then with stalls
   task automatic test_pressure();
      wait_idle();
      no_gaps = 1;
      no_stalls = 1;
      random_items(60);
      req_valid = 1'b0;
      while (next_target_q.size() != 0) @(negedge clock);
      no_stalls = 0;
      random_items(60);
      no_gaps = 0;
   endtask

   initial begin
      spacing_sh = SPACING_RST;
      half_life_sh = HALF_LIFE_RST;
      limit_sh = {28'd0, LIMIT_RST};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_defaults();
      random_items(300);
      test_register_extremes();
      test_random_phase(16'd600, 32'd172800, {36'h0FFFFFFFF, {192{1'b1}}}, 400);
      test_random_phase(16'd1, 32'd1, {228{1'b1}}, 250);
      test_random_phase(16'd65535, 32'hFFFF_FFFF, rand_wide(), 250);
      test_random_phase(16'($urandom), $urandom_range(1, 100000),
         rand_wide() >> $urandom_range(0, 200), 300);
      test_random_phase(16'd120, 32'd3600, {228{1'b1}} >> 100, 300);
      test_pressure();
      wait_idle();
      $display("sent %0d items, checked %0d results, %0d mismatches", items_sent,
         results_seen, mismatches);
      $display("raised to one %0d, limited %0d, bad input %0d", raised_seen,
         limited_seen, bad_seen);
      if (mismatches == 0 && next_target_q.size() == 0)
         $display("tb_asert_target_calc: done, clean");
      else
         $display("tb_asert_target_calc: done, errors");
      $finish;
   end

   initial begin
      #40000000;
      $display("timeout with %0d results outstanding", next_target_q.size());
      $display("tb_asert_target_calc: done, errors");
      $finish;
   end

endmodule
